### sv/icdv_pkg.sv
// Types, character codes and small arithmetic helpers for the ISBN check-digit validator.
package icdv_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 5;
  localparam int unsigned CntW  = 4;
  localparam int unsigned ResW  = 4;

  localparam logic [PosW-1:0] POS_MAX       = 5'd31;
  localparam logic [PosW-1:0] POS_PREFIX    = 5'd4;
  localparam logic [PosW-1:0] POS_HYPHEN    = 5'd8;
  localparam logic [PosW-1:0] SPAN_TEN      = 5'd16;
  localparam logic [PosW-1:0] SPAN_THIRTEEN = 5'd20;
  localparam logic [PosW-1:0] LAST_TEN      = 5'd17;  // length 18
  localparam logic [PosW-1:0] LAST_THIRTEEN = 5'd21;  // length 22

  localparam logic [CntW-1:0] DIGITS_TEN      = 4'd9;
  localparam logic [CntW-1:0] DIGITS_THIRTEEN = 4'd12;
  localparam logic [CntW-1:0] WEIGHT_TOP      = 4'd10;

  localparam logic [CharW-1:0] CHAR_ZERO   = 8'd48;
  localparam logic [CharW-1:0] CHAR_NINE   = 8'd57;
  localparam logic [CharW-1:0] CHAR_X      = 8'd88;
  localparam logic [CharW-1:0] CHAR_HYPHEN = 8'd45;

  localparam logic [CharW-1:0] PREFIX_TEXT [4] = '{8'd73, 8'd83, 8'd66, 8'd78};

  typedef enum logic [1:0] {
    FMT_BAD      = 2'd0,
    FMT_TEN      = 2'd1,
    FMT_THIRTEEN = 2'd2
  } format_kind_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             is_last;
  } isbn_req_t;

  typedef struct packed {
    logic       is_valid;
    logic [1:0] format_kind;
  } isbn_res_t;

  // Reduce a value below 101 modulo 11 by conditional subtraction of 88, 44, 22, 11.
  function automatic logic [ResW-1:0] mod11(input logic [6:0] v);
    logic [6:0] t;
    t = v;
    if (t >= 7'd88) t = t - 7'd88;
    if (t >= 7'd44) t = t - 7'd44;
    if (t >= 7'd22) t = t - 7'd22;
    if (t >= 7'd11) t = t - 7'd11;
    return t[ResW-1:0];
  endfunction

  // Reduce a value below 40 modulo 10.
  function automatic logic [ResW-1:0] mod10(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    if (t >= 6'd20) t = t - 6'd20;
    if (t >= 6'd10) t = t - 6'd10;
    return t[ResW-1:0];
  endfunction

endpackage

### sv/isbn_check_digit_validator_core.sv
// ISBN-10 / ISBN-13 check-digit validator: input register, running residues, result queue.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | in_req_i  : char_code, is_last
//  out     | from block| out_valid_o / out_stall_i| out_res_o : is_valid, format_kind
//
//  One character request is taken every cycle while in_stall_o is low; the per-character
//  work is one small multiply-add and a short modulo reduction between the input register
//  and the state. The result of an is_last request goes to the output or skid register.
//  Reset clears the running state to the start of a new text; no clearing pass is needed.
//  A result that is stalled parks in the output register; one more result fits in a skid
//  register, and in_stall_o (registered) rises only while that skid register is full.
module isbn_check_digit_validator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  icdv_pkg::isbn_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output icdv_pkg::isbn_res_t out_res_o
);
  import icdv_pkg::*;

  // Input register stage
  isbn_req_t req_q;
  logic      req_v_q;

  // Running state of the current text
  logic [PosW-1:0] pos_q, pos_d;
  logic            prefix_q, prefix_d;
  logic            hyphen_q, hyphen_d;
  logic [CntW-1:0] cnt10_q, cnt10_d;
  logic [CntW-1:0] cnt13_q, cnt13_d;
  logic [ResW-1:0] r10_q, r10_d;   // ISBN-10 weighted sum mod 11
  logic [ResW-1:0] r13_q, r13_d;   // ISBN-13 weighted sum mod 10

  // Result queue: output register plus one skid entry
  isbn_res_t main_q, main_d, skid_q, skid_d;
  logic      main_v_q, main_v_d, skid_v_q, skid_v_d;

  logic            accept, proc, pop;
  logic            is_digit;
  logic [3:0]      digit;
  logic            take10, take13;
  logic [CntW-1:0] w10;
  logic [6:0]      prod10;
  logic [5:0]      prod13;
  logic [CharW-1:0] want10, want13;
  isbn_res_t       res;
  logic            res_v;

  // Take a request whenever the skid entry is free; the input stage then always drains.
  assign in_stall_o = skid_v_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign proc       = req_v_q && !skid_v_q;
  assign pop        = main_v_q && !out_stall_i;

  assign out_valid_o = main_v_q;
  assign out_res_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
    end else if (!skid_v_q) begin
      req_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  // Per-character update of the running state and the end-of-text check
  always_comb begin
    is_digit = (req_q.char_code >= CHAR_ZERO) && (req_q.char_code <= CHAR_NINE);
    digit    = req_q.char_code[3:0];
    take10   = is_digit && (pos_q < SPAN_TEN) && (cnt10_q < DIGITS_TEN);
    take13   = is_digit && (pos_q < SPAN_THIRTEEN) && (cnt13_q < DIGITS_THIRTEEN);
    w10      = WEIGHT_TOP - cnt10_q;
    prod10   = 7'(digit) * 7'(w10);
    prod13   = cnt13_q[0] ? (6'(digit) + {1'b0, digit, 1'b0}) : 6'(digit);

    pos_d    = pos_q;
    prefix_d = prefix_q;
    hyphen_d = hyphen_q;
    cnt10_d  = cnt10_q;
    cnt13_d  = cnt13_q;
    r10_d    = r10_q;
    r13_d    = r13_q;

    if ((pos_q < POS_PREFIX) && (req_q.char_code != PREFIX_TEXT[pos_q[1:0]])) begin
      prefix_d = 1'b0;
    end
    if ((pos_q == POS_HYPHEN) && (req_q.char_code == CHAR_HYPHEN)) begin
      hyphen_d = 1'b1;
    end
    if (take10) begin
      r10_d   = mod11(7'(r10_q) + prod10);
      cnt10_d = cnt10_q + 4'd1;
    end
    if (take13) begin
      r13_d   = mod10(6'(r13_q) + prod13);
      cnt13_d = cnt13_q + 4'd1;
    end
    pos_d = (pos_q < POS_MAX) ? pos_q + 5'd1 : POS_MAX;

    // Check characters: residue 0 gives '0', ISBN-10 residue 1 gives 'X'
    if (r10_q == 4'd0) begin
      want10 = CHAR_ZERO;
    end else if (r10_q == 4'd1) begin
      want10 = CHAR_X;
    end else begin
      want10 = CHAR_ZERO + 8'd11 - 8'(r10_q);
    end
    want13 = (r13_q == 4'd0) ? CHAR_ZERO : CHAR_ZERO + 8'd10 - 8'(r13_q);

    res.is_valid    = 1'b0;
    res.format_kind = FMT_BAD;
    if (pos_q == LAST_TEN) begin
      res.format_kind = FMT_TEN;
      res.is_valid    = prefix_q && (cnt10_q == DIGITS_TEN) && (req_q.char_code == want10);
    end else if (pos_q == LAST_THIRTEEN) begin
      res.format_kind = FMT_THIRTEEN;
      res.is_valid    = prefix_q && hyphen_q && (cnt13_q == DIGITS_THIRTEEN)
                        && (req_q.char_code == want13);
    end
    res_v = proc && req_q.is_last;

    // Drop all running state at the end of a text
    if (req_q.is_last) begin
      pos_d    = '0;
      prefix_d = 1'b1;
      hyphen_d = 1'b0;
      cnt10_d  = '0;
      cnt13_d  = '0;
      r10_d    = '0;
      r13_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      prefix_q <= 1'b1;
      hyphen_q <= 1'b0;
      cnt10_q  <= '0;
      cnt13_q  <= '0;
      r10_q    <= '0;
      r13_q    <= '0;
    end else if (proc) begin
      pos_q    <= pos_d;
      prefix_q <= prefix_d;
      hyphen_q <= hyphen_d;
      cnt10_q  <= cnt10_d;
      cnt13_q  <= cnt13_d;
      r10_q    <= r10_d;
      r13_q    <= r13_d;
    end
  end

  // Result queue: advance skid into the output register, else load or park new results
  always_comb begin
    main_d   = main_q;
    main_v_d = main_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (pop) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_v_d = 1'b0;
      end
    end else if (!main_v_q || pop) begin
      main_d   = res;
      main_v_d = res_v;
    end else if (res_v) begin
      skid_d   = res;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry full while output register is empty");

  a_valid_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_v_q && out_res_o.is_valid) |-> (out_res_o.format_kind != FMT_BAD))
    else $error("valid result with bad length");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && req_q.is_last) |=> (pos_q == '0 && cnt10_q == '0 && cnt13_q == '0))
    else $error("running state not cleared after last character");

  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r10_q < 4'd11) && (r13_q < 4'd10))
    else $error("running residue out of range");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_v_q && skid_v_q) |=> req_v_q)
    else $error("input stage dropped a request while stalled");
`endif

endmodule
